### rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AvailW = 3;
  localparam int unsigned CpW    = 21;
  localparam int unsigned UsedW  = 3;
  localparam int unsigned KindW  = 3;
  localparam int unsigned ContLanes = 3;

  localparam logic [KindW-1:0] ERR_TRUNCATED = 3'd0;
  localparam logic [KindW-1:0] ERR_INVALID   = 3'd1;
  localparam logic [KindW-1:0] ERR_OVERLONG  = 3'd2;
  localparam logic [KindW-1:0] ERR_SURROGATE = 3'd3;
  localparam logic [KindW-1:0] ERR_RANGE     = 3'd4;

  localparam logic [CpW-1:0] MIN_CP2       = 21'h000080;
  localparam logic [CpW-1:0] MIN_CP3       = 21'h000800;
  localparam logic [CpW-1:0] MIN_CP4       = 21'h010000;
  localparam logic [CpW-1:0] SURR_LO       = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI       = 21'h00DFFF;
  localparam logic [CpW-1:0] MAX_CP        = 21'h10FFFF;

  // what one continuation-byte lane reports
  typedef struct packed {
    logic       is_cont;
    logic [5:0] payload;
  } lane_t;

  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic [UsedW-1:0] bytes_used;
    logic             rejected;
    logic [KindW-1:0] error_kind;
  } result_t;

endpackage

### rtl/u8d_if.sv
interface u8d_in_if;
  import u8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  first_byte;
  logic [ByteW-1:0]  second_byte;
  logic [ByteW-1:0]  third_byte;
  logic [ByteW-1:0]  fourth_byte;
  logic [AvailW-1:0] avail_bytes;

  modport source(
    output valid, first_byte, second_byte, third_byte, fourth_byte, avail_bytes,
    input  ready
  );
  modport sink(
    input  valid, first_byte, second_byte, third_byte, fourth_byte, avail_bytes,
    output ready
  );
endinterface

interface u8d_out_if;
  import u8d_pkg::*;

  logic             valid;
  logic             ready;
  logic [CpW-1:0]   code_point;
  logic [UsedW-1:0] bytes_used;
  logic             rejected;
  logic [KindW-1:0] error_kind;

  modport source(
    output valid, code_point, bytes_used, rejected, error_kind,
    input  ready
  );
  modport sink(
    input  valid, code_point, bytes_used, rejected, error_kind,
    output ready
  );
endinterface

### rtl/u8d_lane.sv
module u8d_lane (
  input  logic [u8d_pkg::ByteW-1:0] byte_in,
  output u8d_pkg::lane_t            lane
);
  import u8d_pkg::*;

  // continuation bytes look like 10xxxxxx
  assign lane.is_cont = (byte_in[7:6] == 2'b10);
  assign lane.payload = byte_in[5:0];
endmodule

### rtl/u8d_merge.sv
module u8d_merge (
  input  logic [u8d_pkg::ByteW-1:0]                  lead,
  input  logic [u8d_pkg::AvailW-1:0]                 avail,
  input  u8d_pkg::lane_t [u8d_pkg::ContLanes-1:0]    lanes,
  output u8d_pkg::result_t                           res
);
  import u8d_pkg::*;

  logic           is_ascii, is_len2, is_len3, is_len4;
  logic           avail_zero, avail_ge2, avail_ge3, avail_ge4;
  logic [CpW-1:0] cp2, cp3, cp4;

  assign is_ascii = (lead[7] == 1'b0);
  assign is_len2  = (lead[7:5] == 3'b110);
  assign is_len3  = (lead[7:4] == 4'b1110);
  assign is_len4  = (lead[7:3] == 5'b11110);

  // counts of five and up behave as four
  assign avail_zero = (avail == '0);
  assign avail_ge2  = avail[2] | avail[1];
  assign avail_ge3  = avail[2] | (avail[1] & avail[0]);
  assign avail_ge4  = avail[2];

  assign cp2 = {10'd0, lead[4:0], lanes[0].payload};
  assign cp3 = {5'd0, lead[3:0], lanes[0].payload, lanes[1].payload};
  assign cp4 = {lead[2:0], lanes[0].payload, lanes[1].payload, lanes[2].payload};

  always_comb begin
    res = '0;
    if (avail_zero) begin
      res.rejected   = 1'b1;
      res.error_kind = ERR_TRUNCATED;
    end else if (is_ascii) begin
      res.code_point = {13'd0, lead};
      res.bytes_used = 3'd1;
    end else if (is_len2) begin
      if (!avail_ge2) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_TRUNCATED;
      end else if (!lanes[0].is_cont) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_INVALID;
      end else if (cp2 < MIN_CP2) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_OVERLONG;
      end else begin
        res.code_point = cp2;
        res.bytes_used = 3'd2;
      end
    end else if (is_len3) begin
      if (!avail_ge3) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_TRUNCATED;
      end else if (!lanes[0].is_cont || !lanes[1].is_cont) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_INVALID;
      end else if (cp3 < MIN_CP3) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_OVERLONG;
      end else if (cp3 >= SURR_LO && cp3 <= SURR_HI) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_SURROGATE;
      end else begin
        res.code_point = cp3;
        res.bytes_used = 3'd3;
      end
    end else if (is_len4) begin
      if (!avail_ge4) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_TRUNCATED;
      end else if (!lanes[0].is_cont || !lanes[1].is_cont || !lanes[2].is_cont) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_INVALID;
      end else if (cp4 < MIN_CP4) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_OVERLONG;
      end else if (cp4 > MAX_CP) begin
        res.rejected   = 1'b1;
        res.error_kind = ERR_RANGE;
      end else begin
        res.code_point = cp4;
        res.bytes_used = 3'd4;
      end
    end else begin
      // stray continuation byte or lead of 0xf8 and up
      res.rejected   = 1'b1;
      res.error_kind = ERR_INVALID;
    end
  end
endmodule

### rtl/utf8_sequence_decoder.sv
// channel  | modport           | moves
// ---------+-------------------+------------------------------------------
// window   | u8d_in_if.sink    | four bytes at the string head + byte count
// result   | u8d_out_if.source | code point, length used, error flag + kind
//
// one transaction per cycle while window.ready is high; results are registered
// three byte lanes check continuation bytes in parallel, the merge picks by lead
// an output register plus one skid entry keep input flowing under a stall
// window.ready drops only while the skid entry is full
// rst is synchronous and clears both valid flags
module utf8_sequence_decoder (
  input  logic           clk,
  input  logic           rst,
  u8d_in_if.sink         window,
  u8d_out_if.source      result
);
  import u8d_pkg::*;

  logic [ByteW-1:0]              cont_bytes [ContLanes];
  lane_t [ContLanes-1:0]         lanes;
  result_t                       dec;
  result_t                       main_res;
  result_t                       skid_res;
  logic                          out_valid;
  logic                          skid_valid;
  logic                          in_fire;
  logic                          out_fire;

  assign cont_bytes[0] = window.second_byte;
  assign cont_bytes[1] = window.third_byte;
  assign cont_bytes[2] = window.fourth_byte;

  for (genvar i = 0; i < ContLanes; i++) begin : g_lane
    u8d_lane u_lane (
      .byte_in (cont_bytes[i]),
      .lane    (lanes[i])
    );
  end

  u8d_merge u_merge (
    .lead  (window.first_byte),
    .avail (window.avail_bytes),
    .lanes (lanes),
    .res   (dec)
  );

  assign window.ready = !skid_valid;
  assign in_fire      = window.valid && window.ready;
  assign out_fire     = out_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        main_res   <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        main_res  <= dec;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_fire) begin
      skid_res   <= dec;
      skid_valid <= 1'b1;
    end
  end

  assign result.valid      = out_valid;
  assign result.code_point = main_res.code_point;
  assign result.bytes_used = main_res.bytes_used;
  assign result.rejected   = main_res.rejected;
  assign result.error_kind = main_res.error_kind;

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && main_res.rejected) |->
      (main_res.code_point == '0 && main_res.bytes_used == '0))
    else $error("error result carries a code point or length");

  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !main_res.rejected) |->
      (main_res.error_kind == ERR_TRUNCATED && main_res.bytes_used != '0
       && main_res.code_point <= MAX_CP))
    else $error("good result with bad kind, length or value");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (in_fire && out_valid && !result.ready) |=> skid_valid)
    else $error("transaction accepted under stall was not parked");
`endif
endmodule

### tb/sv/utf8_sequence_decoder_tb.sv
module utf8_sequence_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8d_pkg::*;

  typedef struct {
    logic [ByteW-1:0]  b0;
    logic [ByteW-1:0]  b1;
    logic [ByteW-1:0]  b2;
    logic [ByteW-1:0]  b3;
    logic [AvailW-1:0] avail;
    bit                drain_first;
  } window_t;

  logic clk = 1'b0;
  logic rst;

  u8d_in_if  window_if();
  u8d_out_if result_if();

  utf8_sequence_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .window (window_if),
    .result (result_if)
  );

  window_t     pending_windows[$];
  result_t     expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;
  int unsigned taken_count = 0;
  int unsigned send_gap = 0;
  int unsigned sink_hold = 0;
  bit          sender_calm = 1'b0;
  bit          sink_calm = 1'b0;
  bit          long_hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t decode_window(window_t w);
    result_t          r;
    int unsigned      n;
    int unsigned      need;
    logic [CpW-1:0]   cp;
    logic             conts_ok;
    logic             bad;
    logic [KindW-1:0] kind;
    r = '0;
    bad = 1'b0;
    kind = ERR_TRUNCATED;
    n = (w.avail > 4) ? 4 : w.avail;
    if (w.b0[7] == 1'b0) need = 1;
    else if (w.b0[7:5] == 3'b110) need = 2;
    else if (w.b0[7:4] == 4'b1110) need = 3;
    else if (w.b0[7:3] == 5'b11110) need = 4;
    else need = 0;
    case (need)
      1: cp = {13'd0, w.b0};
      2: cp = {10'd0, w.b0[4:0], w.b1[5:0]};
      3: cp = {5'd0, w.b0[3:0], w.b1[5:0], w.b2[5:0]};
      default: cp = {w.b0[2:0], w.b1[5:0], w.b2[5:0], w.b3[5:0]};
    endcase
    conts_ok = (need < 2 || w.b1[7:6] == 2'b10) && (need < 3 || w.b2[7:6] == 2'b10) &&
               (need < 4 || w.b3[7:6] == 2'b10);
    // byte count is checked before the lead byte itself
    if (n == 0 || n < need) begin
      bad = 1'b1;
      kind = ERR_TRUNCATED;
    end else if (need == 0 || !conts_ok) begin
      bad = 1'b1;
      kind = ERR_INVALID;
    end else if ((need == 2 && cp < MIN_CP2) || (need == 3 && cp < MIN_CP3) ||
                 (need == 4 && cp < MIN_CP4)) begin
      bad = 1'b1;
      kind = ERR_OVERLONG;
    end else if (need == 3 && cp >= SURR_LO && cp <= SURR_HI) begin
      bad = 1'b1;
      kind = ERR_SURROGATE;
    end else if (cp > MAX_CP) begin
      bad = 1'b1;
      kind = ERR_RANGE;
    end
    if (bad) begin
      r.rejected = 1'b1;
      r.error_kind = kind;
    end else begin
      r.code_point = cp;
      r.bytes_used = UsedW'(need);
    end
    return r;
  endfunction

  function automatic window_t window_of(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                        logic [7:0] b3, logic [2:0] avail);
    window_t w;
    w.b0 = b0;
    w.b1 = b1;
    w.b2 = b2;
    w.b3 = b3;
    w.avail = avail;
    w.drain_first = 1'b0;
    return w;
  endfunction

  // well-formed bytes for cp at the given length; bytes past the sequence are noise
  function automatic window_t encode_scalar(logic [CpW-1:0] cp, int unsigned len);
    window_t w;
    w = window_of(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                  AvailW'($urandom_range(len, 7)));
    case (len)
      1: w.b0 = {1'b0, cp[6:0]};
      2: begin
        w.b0 = {3'b110, cp[10:6]};
        w.b1 = {2'b10, cp[5:0]};
      end
      3: begin
        w.b0 = {4'b1110, cp[15:12]};
        w.b1 = {2'b10, cp[11:6]};
        w.b2 = {2'b10, cp[5:0]};
      end
      default: begin
        w.b0 = {5'b11110, cp[20:18]};
        w.b1 = {2'b10, cp[17:12]};
        w.b2 = {2'b10, cp[11:6]};
        w.b3 = {2'b10, cp[5:0]};
      end
    endcase
    return w;
  endfunction

  function automatic logic [CpW-1:0] legal_scalar(int unsigned len);
    int unsigned cp;
    case (len)
      1: cp = $urandom_range(0, 'h7F);
      2: cp = $urandom_range('h80, 'h7FF);
      3: begin
        // skip the surrogate block
        cp = $urandom_range('h800, 'hF7FF);
        if (cp >= 'hD800) cp = cp + 'h800;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    return CpW'(cp);
  endfunction

  function automatic window_t random_window();
    window_t     w;
    int unsigned pick;
    int unsigned len;
    int unsigned k;
    int unsigned tops;
    logic [1:0]  top_bits;
    pick = $urandom_range(0, 99);
    len = $urandom_range(1, 4);
    if (pick < 50) begin
      w = encode_scalar(legal_scalar(len), len);
    end else if (pick < 60) begin
      w = encode_scalar(legal_scalar(len), len);
      w.avail = AvailW'($urandom_range(0, len - 1));
    end else if (pick < 70) begin
      len = $urandom_range(2, 4);
      w = encode_scalar(legal_scalar(len), len);
      k = $urandom_range(1, len - 1);
      tops = $urandom_range(0, 2);
      top_bits = (tops == 2) ? 2'b11 : tops[1:0];
      case (k)
        1: w.b1[7:6] = top_bits;
        2: w.b2[7:6] = top_bits;
        default: w.b3[7:6] = top_bits;
      endcase
    end else if (pick < 80) begin
      len = $urandom_range(2, 4);
      case (len)
        2: w = encode_scalar(CpW'($urandom_range(0, 'h7F)), len);
        3: w = encode_scalar(CpW'($urandom_range(0, 'h7FF)), len);
        default: w = encode_scalar(CpW'($urandom_range(0, 'hFFFF)), len);
      endcase
    end else if (pick < 85) begin
      w = encode_scalar(CpW'($urandom_range('hD800, 'hDFFF)), 3);
    end else if (pick < 90) begin
      w = encode_scalar(CpW'($urandom_range('h110000, 'h1FFFFF)), 4);
    end else begin
      w = window_of(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                    AvailW'($urandom_range(0, 7)));
    end
    return w;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 99) < 70) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      window_if.valid <= 1'b0;
      send_gap = 0;
    end else if (!(window_if.valid && !window_if.ready)) begin
      if (window_if.valid) begin
        expected_results.push_back(decode_window(pending_windows.pop_front()));
        sent_count++;
        if (sent_count % 64 == 0) sender_calm = ($urandom_range(0, 2) == 0);
        send_gap = (!sender_calm && $urandom_range(0, 99) < 40) ? idle_length() : 0;
      end
      if (send_gap > 0) begin
        send_gap--;
        window_if.valid <= 1'b0;
      end else if (pending_windows.size() > 0 &&
                   !(pending_windows[0].drain_first && expected_results.size() > 0)) begin
        window_if.valid       <= 1'b1;
        window_if.first_byte  <= pending_windows[0].b0;
        window_if.second_byte <= pending_windows[0].b1;
        window_if.third_byte  <= pending_windows[0].b2;
        window_if.fourth_byte <= pending_windows[0].b3;
        window_if.avail_bytes <= pending_windows[0].avail;
      end else begin
        window_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        taken_count++;
        if (taken_count % 64 == 0) sink_calm = ($urandom_range(0, 2) == 0);
      end
      // one long hold-off so the skid entry fills and the input stalls
      if (taken_count == 300 && !long_hold_done) begin
        long_hold_done = 1'b1;
        sink_hold = 80;
      end
      if (sink_hold == 0 && !sink_calm && $urandom_range(0, 99) < 20)
        sink_hold = idle_length();
      if (sink_hold > 0) begin
        sink_hold--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      seen.code_point = result_if.code_point;
      seen.bytes_used = result_if.bytes_used;
      seen.rejected   = result_if.rejected;
      seen.error_kind = result_if.error_kind;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected: cp %h used %0d err %b kind %0d",
                 $time, seen.code_point, seen.bytes_used, seen.rejected, seen.error_kind);
      end else begin
        want = expected_results.pop_front();
        if (seen.code_point !== want.code_point || seen.bytes_used !== want.bytes_used ||
            seen.rejected !== want.rejected || seen.error_kind !== want.error_kind) begin
          mismatch_count++;
          $display("%0t: expected cp %h used %0d err %b kind %0d got cp %h used %0d err %b kind %0d",
                   $time, want.code_point, want.bytes_used, want.rejected, want.error_kind,
                   seen.code_point, seen.bytes_used, seen.rejected, seen.error_kind);
        end
      end
    end
  end

  initial begin
    window_t w;
    rst = 1'b1;
    window_if.valid = 1'b0;
    window_if.first_byte = '0;
    window_if.second_byte = '0;
    window_if.third_byte = '0;
    window_if.fourth_byte = '0;
    window_if.avail_bytes = '0;
    result_if.ready = 1'b0;

    pending_windows.push_back(window_of(8'h00, 8'h00, 8'h00, 8'h00, 3'd1));
    pending_windows.push_back(window_of(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd4));
    pending_windows.push_back(window_of(8'h41, 8'h80, 8'h80, 8'h80, 3'd0));
    // count above four saturates
    pending_windows.push_back(window_of(8'hF0, 8'h90, 8'h80, 8'h80, 3'd7));
    pending_windows.push_back(window_of(8'hC2, 8'h80, 8'h00, 8'h00, 3'd6));
    // short windows, including ones whose missing bytes would also be bad
    pending_windows.push_back(window_of(8'hC2, 8'h41, 8'h00, 8'h00, 3'd1));
    pending_windows.push_back(window_of(8'hE0, 8'hA0, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window_of(8'hF0, 8'h90, 8'h80, 8'hFF, 3'd3));
    // bad lead bytes
    pending_windows.push_back(window_of(8'h80, 8'h80, 8'h80, 8'h80, 3'd4));
    pending_windows.push_back(window_of(8'hBF, 8'h80, 8'h80, 8'h80, 3'd4));
    pending_windows.push_back(window_of(8'hF8, 8'h88, 8'h80, 8'h80, 3'd4));
    pending_windows.push_back(window_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7));
    // bad continuation bytes
    pending_windows.push_back(window_of(8'hC2, 8'h41, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window_of(8'hE2, 8'h82, 8'hC0, 8'h00, 3'd3));
    pending_windows.push_back(window_of(8'hF0, 8'h90, 8'h80, 8'h7F, 3'd4));
    // overlong forms
    pending_windows.push_back(window_of(8'hC0, 8'h80, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window_of(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window_of(8'hE0, 8'h9F, 8'hBF, 8'h00, 3'd3));
    pending_windows.push_back(window_of(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4));
    // surrogate block edges and the value just below it
    pending_windows.push_back(window_of(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3));
    pending_windows.push_back(window_of(8'hED, 8'hBF, 8'hBF, 8'h00, 3'd3));
    pending_windows.push_back(window_of(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd3));
    // top of lengths two to four, and above the last scalar value
    pending_windows.push_back(window_of(8'hDF, 8'hBF, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window_of(8'hEF, 8'hBF, 8'hBF, 8'h00, 3'd3));
    pending_windows.push_back(window_of(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4));
    pending_windows.push_back(window_of(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4));
    pending_windows.push_back(window_of(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd5));

    for (int i = 0; i < 1000; i++) begin
      w = random_window();
      if (i == 0 || i == 500) w.drain_first = 1'b1;
      pending_windows.push_back(w);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (pending_windows.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("utf8_sequence_decoder: match");
    else
      $display("utf8_sequence_decoder: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("utf8_sequence_decoder: mismatch");
    $finish;
  end

endmodule
